// ===== rtl/spq_pkg.sv =====
package spq_pkg;

  // Queue size and derived widths
  localparam int DEPTH   = 16;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int FIELD_W = 16;
  localparam int OCC_W   = 5;

  // Operation codes (s_tuser)
  localparam logic [1:0] OP_ENQ  = 2'd0;
  localparam logic [1:0] OP_DEQ  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DUP   = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  // One queue entry
  typedef struct packed {
    logic [FIELD_W-1:0] key;
    logic [FIELD_W-1:0] prio;
    logic [FIELD_W-1:0] tag;
  } entry_t;

  // Contents of one cell
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } slot_t;

  // Broadcast control from the top to every cell
  typedef struct packed {
    logic   enq;   // commit an insert this cycle
    logic   deq;   // commit a head removal this cycle
    entry_t item;  // incoming entry, also drives the compares
  } cell_ctrl_t;

endpackage

// ===== rtl/spq_cell.sv =====
module spq_cell (
  input  logic               clk,
  input  logic               rst,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  spq_pkg::slot_t     left,
  input  logic               left_stay,
  input  spq_pkg::slot_t     right,
  output spq_pkg::slot_t     slot,
  output logic               stay,
  output logic               match
);
  import spq_pkg::*;

  slot_t slot_next;

  // Compares against the incoming entry
  assign stay  = slot.valid && (slot.entry.prio <= ctrl.item.prio);
  assign match = slot.valid && (slot.entry.key == ctrl.item.key);

  // Insert: hold, take the new entry, or shift in from the left.
  // Remove: shift in from the right.
  always_comb begin
    slot_next = slot;
    if (ctrl.enq) begin
      if (stay) begin
        slot_next = slot;
      end else if (left_stay) begin
        slot_next.valid = 1'b1;
        slot_next.entry = ctrl.item;
      end else begin
        slot_next = left;
      end
    end else if (ctrl.deq) begin
      slot_next = right;
    end
  end

  // Valid bit with reset, payload without
  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
    end else begin
      slot.valid <= slot_next.valid;
    end
    slot.entry <= slot_next.entry;
  end

endmodule

// ===== rtl/sorted_priority_queue_unique_key_unit.sv =====
// Channel  Dir  Handshake          tdata                               tuser
// s_*      in   s_tvalid/s_tready  key, priority_req, tag (48 bits)    op
// m_*      out  m_tvalid/m_tready  out_key, out_priority, out_tag,     status, out_valid
//                                  occupancy (53 bits, 56 wide)
// One word per cycle while s_tready is high: every cell compares and shifts in the cycle a word is taken,
// and the result sits in one output register, presented in the cycle after.
// s_tready drops only while a result waits in the output register and m_tready is low.
// rst clears the cell valid bits, the entry count and the output valid flag.
module sorted_priority_queue_unique_key_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // [15:0] key, [31:16] priority_req, [47:32] tag
  input  logic [1:0]  s_tuser,   // [1:0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [15:0] out_key, [31:16] out_priority,
                                 // [47:32] out_tag, [52:48] occupancy, rest zero
  output logic [2:0]  m_tuser    // [1:0] status, [2] out_valid
);
  import spq_pkg::*;

  logic             accept;
  logic [1:0]       op;
  cell_ctrl_t       ctrl;
  slot_t            slots [DEPTH];
  logic [DEPTH-1:0] stays;
  logic [DEPTH-1:0] key_hits;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             dup, full, empty;
  logic [1:0]       status_next;
  logic             hit_next;
  entry_t           head_next;
  logic [1:0]       status;
  logic             hit;
  entry_t           head;
  logic [OCC_W-1:0] occ;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign op       = s_tuser;

  // Decode incoming word
  assign ctrl.item.key  = s_tdata[15:0];
  assign ctrl.item.prio = s_tdata[31:16];
  assign ctrl.item.tag  = s_tdata[47:32];

  assign dup   = |key_hits;
  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);

  assign ctrl.enq = accept && (op == OP_ENQ) && !dup && !full;
  assign ctrl.deq = accept && (op == OP_DEQ) && !empty;

  // Chain of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    slot_t left_slot;
    slot_t right_slot;
    logic  left_stay;

    if (i == 0) begin : g_first
      assign left_slot = '{valid: 1'b1, entry: ctrl.item};
      assign left_stay = 1'b1;
    end else begin : g_mid
      assign left_slot = slots[i-1];
      assign left_stay = stays[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_slot = '{valid: 1'b0, entry: slots[i].entry};
    end else begin : g_inner
      assign right_slot = slots[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .left      (left_slot),
      .left_stay (left_stay),
      .right     (right_slot),
      .slot      (slots[i]),
      .stay      (stays[i]),
      .match     (key_hits[i])
    );
  end

  // Result and count for the accepted word
  always_comb begin
    status_next = ST_OK;
    hit_next    = 1'b0;
    head_next   = '0;
    count_next  = count;
    case (op)
      OP_ENQ: begin
        if (dup) begin
          status_next = ST_DUP;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + 1'b1;
        end
      end
      OP_DEQ, OP_PEEK: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          hit_next  = 1'b1;
          head_next = slots[0].entry;
          if (op == OP_DEQ) begin
            count_next = count - 1'b1;
          end
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // Output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
      hit    <= hit_next;
      head   <= head_next;
      occ    <= OCC_W'(count_next);
    end
  end

  assign m_tdata = {3'b000, occ, head.tag, head.prio, head.key};
  assign m_tuser = {hit, status};

endmodule

// ===== test/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  // Unused op code, the block answers it without touching the queue
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam int RAND_WORDS  = 1800;
  localparam int MAX_GAP     = 18;
  localparam int LONG_HOLD   = 300;
  localparam int HOLD_AT_A   = 400;
  localparam int HOLD_AT_B   = 1300;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_LIMIT = 5000;
  localparam int TAIL_CYCLES = 20;

  // One operation waiting to be sent, with the idle cycles before it
  typedef struct {
    logic [1:0] op;
    entry_t     e;
    int         gap;
  } queue_req_t;

  // Everything one result word carries
  typedef struct packed {
    logic [1:0]       status;
    logic             out_valid;
    entry_t           head;
    logic [OCC_W-1:0] occ;
  } queue_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic [2:0]  m_tuser;

  // Shadow copy of the sorted queue
  entry_t shadow_q[DEPTH];
  int     shadow_cnt = 0;

  queue_req_t   pending_reqs[$];
  queue_reply_t awaited_replies[$];

  int     err_cnt    = 0;
  int     tx_wait    = 0;
  int     rx_wait    = 0;
  int     words_seen = 0;
  bit     tx_busy    = 1'b1;
  bit     rx_busy    = 1'b1;
  longint cycle_cnt  = 0;

  sorted_priority_queue_unique_key_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // Apply one operation to the shadow queue and return the word it should produce
  function automatic queue_reply_t run_queue_op(input logic [1:0] op, input entry_t req);
    queue_reply_t r;
    int           pos;
    int           i;
    bit           dup;
    r   = '0;
    dup = 1'b0;
    if (op == OP_ENQ) begin
      // duplicate check wins over full
      for (i = 0; i < shadow_cnt; i++)
        if (shadow_q[i].key == req.key) dup = 1'b1;
      if (dup) begin
        r.status = ST_DUP;
      end else if (shadow_cnt >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // behind every entry with priority <= new one, so ties stay FIFO
        pos = 0;
        while (pos < shadow_cnt && shadow_q[pos].prio <= req.prio) pos++;
        for (i = shadow_cnt; i > pos; i--) shadow_q[i] = shadow_q[i-1];
        shadow_q[pos] = req;
        shadow_cnt++;
      end
    end else if (op == OP_DEQ || op == OP_PEEK) begin
      if (shadow_cnt == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.out_valid = 1'b1;
        r.head      = shadow_q[0];
        if (op == OP_DEQ) begin
          for (i = 0; i + 1 < shadow_cnt; i++) shadow_q[i] = shadow_q[i+1];
          shadow_cnt--;
        end
      end
    end
    r.occ = OCC_W'(shadow_cnt);
    return r;
  endfunction

  task automatic push_req(input logic [1:0] op, input logic [15:0] key,
                          input logic [15:0] prio, input logic [15:0] tag);
    queue_req_t q;
    q.op     = op;
    q.e.key  = key;
    q.e.prio = prio;
    q.e.tag  = tag;
    q.gap    = tx_busy ? $urandom_range(MAX_GAP) : 0;
    pending_reqs.push_back(q);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
    err_cnt++;
  endtask

  // Sender: present queued operations, honoring each one's idle gap
  always @(posedge clk) begin : sender
    queue_req_t nxt;
    entry_t     taken;
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_wait = 0;
    end else begin
      // word taken at this edge
      if (s_tvalid && s_tready) begin
        taken.key  = s_tdata[15:0];
        taken.prio = s_tdata[31:16];
        taken.tag  = s_tdata[47:32];
        awaited_replies.push_back(run_queue_op(s_tuser, taken));
      end
      if (!s_tvalid || s_tready) begin
        if (pending_reqs.size() == 0) begin
          s_tvalid <= 1'b0;
        end else if (tx_wait < pending_reqs[0].gap) begin
          tx_wait++;
          s_tvalid <= 1'b0;
        end else begin
          nxt = pending_reqs.pop_front();
          tx_wait = 0;
          s_tvalid <= 1'b1;
          s_tdata  <= {nxt.e.tag, nxt.e.prio, nxt.e.key};
          s_tuser  <= nxt.op;
        end
      end
    end
  end

  // Receiver: check each result word, then stall for a drawn number of cycles
  always @(posedge clk) begin : receiver
    queue_reply_t want;
    logic         ready_next;
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      ready_next = 1'b1;
      if (m_tvalid && m_tready) begin
        if (awaited_replies.size() == 0) begin
          report_mismatch("word with nothing awaited", m_tdata, 0);
        end else begin
          want = awaited_replies.pop_front();
          if (m_tuser[1:0] !== want.status)
            report_mismatch("status", m_tuser[1:0], want.status);
          if (m_tuser[2] !== want.out_valid)
            report_mismatch("out_valid", m_tuser[2], want.out_valid);
          if (m_tdata[15:0] !== want.head.key)
            report_mismatch("out_key", m_tdata[15:0], want.head.key);
          if (m_tdata[31:16] !== want.head.prio)
            report_mismatch("out_priority", m_tdata[31:16], want.head.prio);
          if (m_tdata[47:32] !== want.head.tag)
            report_mismatch("out_tag", m_tdata[47:32], want.head.tag);
          if (m_tdata[52:48] !== want.occ)
            report_mismatch("occupancy", m_tdata[52:48], want.occ);
          if (m_tdata[55:53] !== 3'b000)
            report_mismatch("tdata padding", m_tdata[55:53], 0);
        end
        words_seen++;
        if (words_seen % 100 == 0) rx_busy = ($urandom_range(2) != 0);
        rx_wait = rx_busy ? $urandom_range(MAX_GAP) : 0;
        // long hold-off so the output register fills and input backs up
        if (words_seen == HOLD_AT_A || words_seen == HOLD_AT_B) rx_wait = LONG_HOLD;
        ready_next = (rx_wait == 0);
      end else if (rx_wait != 0) begin
        rx_wait--;
        ready_next = (rx_wait == 0);
      end
      m_tready <= ready_next;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int         i;
    int         n;
    int         bias;
    int         roll;
    logic [1:0] op;
    logic [15:0] k;
    logic [15:0] p;

    // empty queue reads and the unused op code
    push_req(OP_PEEK, 16'h0000, 16'h0000, 16'h0000);
    push_req(OP_DEQ, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_req(OP_NONE, 16'hA5A5, 16'h5A5A, 16'hFFFF);
    // field extremes and priority ties
    push_req(OP_ENQ, 16'h0000, 16'h0005, 16'h0000);
    push_req(OP_ENQ, 16'hFFFF, 16'h0005, 16'hFFFF);
    push_req(OP_ENQ, 16'h1234, 16'hFFFF, 16'hAAAA);
    push_req(OP_ENQ, 16'h4321, 16'h0000, 16'h5555);
    push_req(OP_ENQ, 16'h0001, 16'h0005, 16'h0001);
    push_req(OP_ENQ, 16'h8000, 16'h0000, 16'h8000);
    // duplicate key with room left
    push_req(OP_ENQ, 16'h1234, 16'h0001, 16'h0BAD);
    // fill to the top
    for (i = 0; i < 10; i++)
      push_req(OP_ENQ, 16'h0100 + 16'(i), 16'(i % 3) + 16'd3, 16'($urandom));
    // full queue, then duplicate while full
    push_req(OP_ENQ, 16'h7777, 16'h0002, 16'h7777);
    push_req(OP_ENQ, 16'hFFFF, 16'h0002, 16'h1111);
    push_req(OP_PEEK, 16'h0000, 16'h0000, 16'h0000);
    push_req(OP_DEQ, 16'h0000, 16'h0000, 16'h0000);
    push_req(OP_NONE, 16'h0000, 16'h0000, 16'h0000);

    // random part: phases lean toward filling, mixing or draining
    bias = 50;
    for (i = 0; i < RAND_WORDS; i++) begin
      if (i % 60 == 0) begin
        case ($urandom_range(2))
          0: bias = 85;
          1: bias = 50;
          default: bias = 20;
        endcase
        tx_busy = ($urandom_range(3) != 0);
      end
      roll = $urandom_range(99);
      if (roll < 3) begin
        op = OP_NONE;
      end else begin
        roll = $urandom_range(99);
        if (roll < bias) op = OP_ENQ;
        else if (roll < bias + (100 - bias) * 2 / 3) op = OP_DEQ;
        else op = OP_PEEK;
      end
      // small key pool makes duplicates common
      k = ($urandom_range(9) < 6) ? 16'($urandom_range(23)) : 16'($urandom);
      p = ($urandom_range(1) != 0) ? 16'($urandom_range(7)) : 16'($urandom);
      push_req(op, k, p, 16'($urandom));
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || s_tvalid) @(posedge clk);
    n = 0;
    while (awaited_replies.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    if (awaited_replies.size() != 0)
      report_mismatch("words never returned", awaited_replies.size(), 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_unique_key_unit.sv
test/tb_top.sv
